/* rtl/core/kqf_pkg.sv */
`default_nettype none
package kqf_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int FRAC_BITS      = 8;
  localparam int VALUE_BITS     = 24;
  localparam int BAND_BITS      = 3;
  localparam int SIZE_BITS      = 4;
  localparam int NUM_QUAD       = 4;
  localparam int DEF_MAX_WINDOW = 15;
  localparam int CFG_AW         = 4;
  localparam int CFG_DW         = 32;

  typedef enum logic [1:0] {
    REG_WINDOW_SIZE   = 2'd0,
    REG_USE_NO_DATA   = 2'd1,
    REG_NO_DATA_VALUE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] pixel_value;
    logic [BAND_BITS-1:0]          band;
    logic                          last_pixel;
  } pixel_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] filtered_value;
    logic                         is_no_data;
    logic [BAND_BITS-1:0]         band_out;
    logic [1:0]                   chosen_quadrant;
  } result_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SPR_MUL,
    B_SPR_SUB,
    B_CMP_SQ,
    B_CMP_MUL,
    B_CMP_DEC,
    B_DIV_INIT,
    B_DIV,
    B_FIN,
    B_OUT
  } back_state_t;

  // Widths of the per-quadrant statistics, from the largest quadrant side.
  function automatic int cnt_w(input int side);
    return $clog2(side * side + 1);
  endfunction

  function automatic int sum_w(input int side);
    return SAMPLE_BITS + cnt_w(side);
  endfunction

  function automatic int sq_w(input int side);
    return 2 * SAMPLE_BITS - 1 + cnt_w(side);
  endfunction

  function automatic int entry_w(input int side);
    return NUM_QUAD * (cnt_w(side) + sum_w(side) + sq_w(side)) + BAND_BITS;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/kqf_front.sv */
`default_nettype none
module kqf_front #(
  parameter int MAX_WINDOW = kqf_pkg::DEF_MAX_WINDOW,
  parameter int EW = kqf_pkg::entry_w(MAX_WINDOW / 2)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  pixel_valid,
  output logic                                       pixel_ready,
  input  wire kqf_pkg::pixel_t                       pixel,
  input  wire logic [kqf_pkg::SIZE_BITS-1:0]         window_size,
  input  wire logic                                  use_no_data,
  input  wire logic signed [kqf_pkg::SAMPLE_BITS-1:0] no_data_value,
  input  wire logic                                  q_full,
  output logic                                       q_push,
  output logic [EW-1:0]                              q_data
);
  import kqf_pkg::*;

  localparam int HALF = MAX_WINDOW / 2;
  localparam int CW   = cnt_w(HALF);
  localparam int SW   = sum_w(HALF);
  localparam int QW2  = sq_w(HALF);
  localparam int QW   = CW + SW + QW2;
  localparam int PW   = $clog2(MAX_WINDOW + 1);
  localparam int GW   = ((PW > SIZE_BITS) ? PW : SIZE_BITS) + 1;

  logic [CW-1:0]        cnt [NUM_QUAD];
  logic signed [SW-1:0] sum [NUM_QUAD];
  logic [QW2-1:0]       sq  [NUM_QUAD];
  logic [CW-1:0]        cnt_next [NUM_QUAD];
  logic signed [SW-1:0] sum_next [NUM_QUAD];
  logic [QW2-1:0]       sq_next  [NUM_QUAD];
  logic [PW-1:0]        row;
  logic [PW-1:0]        col;

  logic                 accept;
  logic [GW-1:0]        w, h, r, c, c_inc;
  logic                 top, bot, lft, rgt, take;
  logic [1:0]           quad;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] mag_sq;

  assign pixel_ready = !q_full;
  assign accept      = pixel_valid && pixel_ready;

  always_comb begin
    w = (GW'(window_size) > GW'(MAX_WINDOW)) ? GW'(MAX_WINDOW) : GW'(window_size);
    h = (w != '0) ? ((w - GW'(1)) >> 1) : '0;
    r = GW'(row);
    c = GW'(col);
    c_inc = c + GW'(1);
    top = r < h;
    bot = (r > h) && (r < w);
    lft = c < h;
    rgt = (c > h) && (c < w);
    take = (top || bot) && (lft || rgt) &&
           !(use_no_data && (pixel.pixel_value == no_data_value));
    quad = {rgt, bot};
    mag = pixel.pixel_value[SAMPLE_BITS-1] ? SAMPLE_BITS'(-pixel.pixel_value)
                                           : SAMPLE_BITS'(pixel.pixel_value);
    mag_sq = mag * mag;
    for (int q = 0; q < NUM_QUAD; q++) begin
      cnt_next[q] = cnt[q];
      sum_next[q] = sum[q];
      sq_next[q]  = sq[q];
      if (take && (quad == 2'(q))) begin
        cnt_next[q] = cnt[q] + CW'(1);
        sum_next[q] = sum[q] + SW'(pixel.pixel_value);
        sq_next[q]  = sq[q] + QW2'(mag_sq);
      end
    end
  end

  // The entry holds the window totals including the closing pixel.
  always_comb begin
    q_data = '0;
    for (int q = 0; q < NUM_QUAD; q++) begin
      q_data[q*QW +: QW] = {cnt_next[q], sum_next[q], sq_next[q]};
    end
    q_data[EW-1 -: BAND_BITS] = pixel.band;
  end

  assign q_push = accept && pixel.last_pixel;

  always_ff @(posedge clk) begin
    if (rst || q_push) begin
      row <= '0;
      col <= '0;
      for (int q = 0; q < NUM_QUAD; q++) begin
        cnt[q] <= '0;
        sum[q] <= '0;
        sq[q]  <= '0;
      end
    end else if (accept) begin
      for (int q = 0; q < NUM_QUAD; q++) begin
        cnt[q] <= cnt_next[q];
        sum[q] <= sum_next[q];
        sq[q]  <= sq_next[q];
      end
      if (c_inc >= w) begin
        col <= '0;
        if (row < PW'(MAX_WINDOW)) begin
          row <= row + PW'(1);
        end
      end else begin
        col <= c_inc[PW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/kqf_fifo.sv */
`default_nettype none
module kqf_fifo #(
  parameter int EW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [EW-1:0] push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output logic [EW-1:0]      pop_data
);
  import kqf_pkg::*;

  logic [EW-1:0] mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("window entry pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("window entry popped from an empty queue");
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue fill count out of range");
`endif

endmodule
`default_nettype wire

/* rtl/core/kqf_back.sv */
`default_nettype none
module kqf_back #(
  parameter int MAX_WINDOW = kqf_pkg::DEF_MAX_WINDOW,
  parameter int EW = kqf_pkg::entry_w(MAX_WINDOW / 2)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  q_valid,
  input  wire logic [EW-1:0]                         q_data,
  output logic                                       q_pop,
  input  wire logic signed [kqf_pkg::SAMPLE_BITS-1:0] no_data_value,
  output logic                                       result_valid,
  input  wire logic                                  result_ready,
  output kqf_pkg::result_t                           result
);
  import kqf_pkg::*;

  localparam int HALF = MAX_WINDOW / 2;
  localparam int CW   = cnt_w(HALF);
  localparam int SW   = sum_w(HALF);
  localparam int QW2  = sq_w(HALF);
  localparam int QW   = CW + SW + QW2;
  localparam int PSW  = CW + QW2;
  localparam int LW   = PSW + 2 * CW;
  localparam int DW   = SW + FRAC_BITS;
  localparam int DCW  = $clog2(DW + 1);

  back_state_t state, state_next;

  logic [CW-1:0]        cnt [NUM_QUAD];
  logic signed [SW-1:0] sum [NUM_QUAD];
  logic [QW2-1:0]       sq  [NUM_QUAD];
  logic [PSW-1:0]       spr [NUM_QUAD];
  logic [BAND_BITS-1:0] band;
  logic                 empty;
  logic [1:0]           k;
  logic [1:0]           best;
  logic [PSW-1:0]       p1;
  logic [2*SW-1:0]      p2;
  logic [2*CW-1:0]      nb2, nq2;
  logic [LW-1:0]        lhs, rhs;
  logic [DW-1:0]        dvd;
  logic [CW:0]          rem;
  logic [DCW-1:0]       dcnt;
  logic                 neg;
  result_t              res;

  logic                 load_empty;
  logic [SW-1:0]        sum_mag;
  logic [CW:0]          rem_sh;
  logic                 rem_ge;
  logic [DW-1:0]        quo_signed;

  always_comb begin
    load_empty = 1'b0;
    for (int q = 0; q < NUM_QUAD; q++) begin
      if (q_data[q*QW + QW2 + SW +: CW] == '0) begin
        load_empty = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:     if (q_valid) begin
                    state_next = load_empty ? B_OUT : B_SPR_MUL;
                  end
      B_SPR_MUL:  state_next = B_SPR_SUB;
      B_SPR_SUB:  state_next = (k == 2'd3) ? B_CMP_SQ : B_SPR_MUL;
      B_CMP_SQ:   state_next = B_CMP_MUL;
      B_CMP_MUL:  state_next = B_CMP_DEC;
      B_CMP_DEC:  state_next = (k == 2'd3) ? B_DIV_INIT : B_CMP_SQ;
      B_DIV_INIT: state_next = B_DIV;
      B_DIV:      if (dcnt == DCW'(DW - 1)) begin
                    state_next = B_FIN;
                  end
      B_FIN:      state_next = B_OUT;
      B_OUT:      if (result_ready) begin
                    state_next = B_IDLE;
                  end
      default:    state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = (state == B_IDLE) && q_valid;
    result_valid = (state == B_OUT);
  end

  assign result = res;

  always_comb begin
    sum_mag    = sum[best][SW-1] ? SW'(-sum[best]) : SW'(sum[best]);
    rem_sh     = {rem[CW-1:0], dvd[DW-1]};
    rem_ge     = rem_sh >= {1'b0, cnt[best]};
    quo_signed = neg ? (DW'(0) - dvd) : dvd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          for (int q = 0; q < NUM_QUAD; q++) begin
            {cnt[q], sum[q], sq[q]} <= q_data[q*QW +: QW];
          end
          band  <= q_data[EW-1 -: BAND_BITS];
          empty <= load_empty;
          k     <= 2'd0;
          best  <= 2'd0;
          res.filtered_value  <= {no_data_value, {FRAC_BITS{1'b0}}};
          res.is_no_data      <= 1'b1;
          res.band_out        <= q_data[EW-1 -: BAND_BITS];
          res.chosen_quadrant <= 2'd0;
        end
      end
      B_SPR_MUL: begin
        p1 <= cnt[k] * sq[k];
        p2 <= (sum[k][SW-1] ? SW'(-sum[k]) : SW'(sum[k])) *
              (sum[k][SW-1] ? SW'(-sum[k]) : SW'(sum[k]));
      end
      B_SPR_SUB: begin
        // n*S2 - S^2 cannot go negative, so the truncated square is safe.
        spr[k] <= p1 - PSW'(p2);
        k      <= (k == 2'd3) ? 2'd1 : k + 2'd1;
      end
      B_CMP_SQ: begin
        nb2 <= cnt[best] * cnt[best];
        nq2 <= cnt[k] * cnt[k];
      end
      B_CMP_MUL: begin
        lhs <= spr[k] * nb2;
        rhs <= spr[best] * nq2;
      end
      B_CMP_DEC: begin
        if (lhs < rhs) begin
          best <= k;
        end
        k <= k + 2'd1;
      end
      B_DIV_INIT: begin
        dvd  <= {sum_mag, {FRAC_BITS{1'b0}}};
        neg  <= sum[best][SW-1];
        rem  <= '0;
        dcnt <= '0;
      end
      B_DIV: begin
        rem  <= rem_ge ? (rem_sh - {1'b0, cnt[best]}) : rem_sh;
        dvd  <= {dvd[DW-2:0], rem_ge};
        dcnt <= dcnt + DCW'(1);
      end
      B_FIN: begin
        res.filtered_value  <= quo_signed[VALUE_BITS-1:0];
        res.is_no_data      <= 1'b0;
        res.band_out        <= band;
        res.chosen_quadrant <= best;
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_nodata_quad: assert property (@(posedge clk) disable iff (rst)
      result_valid && result.is_no_data |-> result.chosen_quadrant == 2'd0)
    else $error("no-data result must report quadrant zero");
  a_empty_skips: assert property (@(posedge clk) disable iff (rst)
      (state == B_SPR_MUL) |-> !empty)
    else $error("variance pass started on a window with an empty quadrant");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
      (state == B_DIV) |-> dcnt < DCW'(DW))
    else $error("divider ran past its last step");
`endif

endmodule
`default_nettype wire

/* rtl/core/kuwahara_quadrant_filter.sv */
`default_nettype none
// Kuwahara quadrant filter: takes one square window row-major, one pixel a cycle while
// pixel_ready is high, and returns the mean (signed Q16.8) of the corner quadrant with the
// least variance, or the no-data value if any quadrant is empty, one result per window
// after the pixel flagged last. The front accumulates pixels at one per cycle while the
// queue has room, and hands window totals to a two-entry queue; the back works on one window
// at a time, its pace set by the sequenced variance multipliers and the bit-serial restoring
// divider. Pixel input stalls only once both queue entries are full.
module kuwahara_quadrant_filter #(
  parameter int MAX_WINDOW = kqf_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          pixel_valid,
  output logic                               pixel_ready,
  input  wire kqf_pkg::pixel_t               pixel,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output kqf_pkg::result_t                   result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [kqf_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [kqf_pkg::CFG_DW-1:0]    pwdata,
  output logic [kqf_pkg::CFG_DW-1:0]         prdata,
  output logic                               pready
);
  import kqf_pkg::*;

  localparam int EW = entry_w(MAX_WINDOW / 2);

  logic [SIZE_BITS-1:0]          window_size;
  logic                          use_no_data;
  logic signed [SAMPLE_BITS-1:0] no_data_value;
  logic                          cfg_wr;
  reg_idx_t                      reg_idx;

  logic          q_push, q_full, q_pop, q_valid;
  logic [EW-1:0] q_in, q_out;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= SIZE_BITS'(3);
      use_no_data   <= 1'b0;
      no_data_value <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WINDOW_SIZE:   window_size   <= pwdata[SIZE_BITS-1:0];
        REG_USE_NO_DATA:   use_no_data   <= pwdata[0];
        REG_NO_DATA_VALUE: no_data_value <= pwdata[SAMPLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_SIZE:   prdata = CFG_DW'(window_size);
      REG_USE_NO_DATA:   prdata = CFG_DW'(use_no_data);
      REG_NO_DATA_VALUE: prdata = CFG_DW'(no_data_value);
      default:           prdata = '0;
    endcase
  end

  kqf_front #(.MAX_WINDOW(MAX_WINDOW), .EW(EW)) u_front (
    .clk           (clk),
    .rst           (rst),
    .pixel_valid   (pixel_valid),
    .pixel_ready   (pixel_ready),
    .pixel         (pixel),
    .window_size   (window_size),
    .use_no_data   (use_no_data),
    .no_data_value (no_data_value),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  kqf_fifo #(.EW(EW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  kqf_back #(.MAX_WINDOW(MAX_WINDOW), .EW(EW)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_out),
    .q_pop         (q_pop),
    .no_data_value (no_data_value),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result)
  );

endmodule
`default_nettype wire
